@@ sv/fsbc_pkg.sv @@
// Shared types and constants for the frustum sphere/box cull block.
package fsbc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int LANE_COUNT  = 4;
    localparam int LANE_STRIDE = 16;
    localparam int AXIS_COUNT  = 3;
    localparam int VEC_COUNT   = AXIS_COUNT + 1;
    localparam int WORD_W      = 64;
    localparam int ADDR_W      = 6;
    localparam int RAD_W       = 16;
    // Q8.8 radius to Q16.16
    localparam int RAD_SHIFT   = 8;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [2:0]        reg_idx_t;

    // far plane is the last register
    localparam reg_idx_t REG_LAST = 3'd5;

    localparam logic OP_SPHERE = 1'b0;
    localparam logic OP_BOX    = 1'b1;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } stage_ctl_t;

endpackage

@@ sv/fsbc_regs.sv @@
// APB register file holding the six frustum planes.
module fsbc_regs (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [fsbc_pkg::ADDR_W-1:0]                   paddr,
    input  fsbc_pkg::word_t                               pwdata,
    output fsbc_pkg::word_t                               prdata,
    output logic                                          pready,
    output fsbc_pkg::word_t [fsbc_pkg::PLANE_COUNT-1:0]   planes
);

    fsbc_pkg::word_t    plane_reg [fsbc_pkg::PLANE_COUNT];
    fsbc_pkg::reg_idx_t idx;
    logic               idx_ok;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = paddr[fsbc_pkg::ADDR_W-1:3];
    assign idx_ok = (idx <= fsbc_pkg::REG_LAST);
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (wr_en && idx_ok)
        begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = idx_ok ? plane_reg[idx] : '0;
        for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
        begin
            planes[i] = plane_reg[i];
        end
    end

endmodule

@@ sv/fsbc_plane.sv @@
// Per-plane datapath: lane products, dot sums, center dot and sum of absolute axis dots.
module fsbc_plane #(
    parameter  int COMPONENT_BITS = 16,
    localparam int DOT_W          = 2 * COMPONENT_BITS + 2,
    localparam int SABS_W         = 2 * COMPONENT_BITS + 3
) (
    input  logic                                        clk,
    input  fsbc_pkg::stage_ctl_t                        ctl,
    input  fsbc_pkg::word_t                             plane,
    input  fsbc_pkg::word_t [fsbc_pkg::VEC_COUNT-1:0]   vecs,
    output logic signed [DOT_W-1:0]                     dc,
    output logic [SABS_W-1:0]                           sabs
);

    localparam int C      = COMPONENT_BITS;
    localparam int PROD_W = 2 * C;
    localparam int ABS_W  = 2 * C + 1;

    logic signed [PROD_W-1:0] prod_reg [fsbc_pkg::VEC_COUNT][fsbc_pkg::LANE_COUNT];
    logic signed [DOT_W-1:0]  dot_reg  [fsbc_pkg::VEC_COUNT];
    logic [ABS_W-1:0]         abs_val  [fsbc_pkg::AXIS_COUNT];
    logic signed [DOT_W-1:0]  dc_reg;
    logic [SABS_W-1:0]        sabs_reg;
    logic [SABS_W-1:0]        sabs_next;

    // stage 1: lane products, vector 0 is the center, 1..3 the box axes
    for (genvar v = 0; v < fsbc_pkg::VEC_COUNT; v++)
    begin : g_vec
        for (genvar k = 0; k < fsbc_pkg::LANE_COUNT; k++)
        begin : g_lane
            logic signed [C-1:0] pa;
            logic signed [C-1:0] vb;

            assign pa = plane[fsbc_pkg::LANE_STRIDE*k +: C];
            assign vb = vecs[v][fsbc_pkg::LANE_STRIDE*k +: C];

            always_ff @(posedge clk)
            begin
                if (ctl.adv1)
                begin
                    prod_reg[v][k] <= pa * vb;
                end
            end
        end

        // stage 2: four-lane dot sum at full width
        always_ff @(posedge clk)
        begin
            if (ctl.adv2)
            begin
                dot_reg[v] <= DOT_W'(prod_reg[v][0]) + DOT_W'(prod_reg[v][1])
                            + DOT_W'(prod_reg[v][2]) + DOT_W'(prod_reg[v][3]);
            end
        end
    end

    // stage 3: absolute axis dots; magnitude never exceeds 2^(2C)
    for (genvar a = 0; a < fsbc_pkg::AXIS_COUNT; a++)
    begin : g_abs
        logic signed [DOT_W-1:0] neg;

        assign neg        = -dot_reg[a+1];
        assign abs_val[a] = dot_reg[a+1][DOT_W-1] ? neg[ABS_W-1:0]
                                                  : dot_reg[a+1][ABS_W-1:0];
    end

    assign sabs_next = SABS_W'(abs_val[0]) + SABS_W'(abs_val[1]) + SABS_W'(abs_val[2]);

    always_ff @(posedge clk)
    begin
        if (ctl.adv3)
        begin
            dc_reg   <= dot_reg[0];
            sabs_reg <= sabs_next;
        end
    end

    assign dc   = dc_reg;
    assign sabs = sabs_reg;

endmodule

@@ sv/frustum_sphere_box_cull.sv @@
// Top level: frustum cull of one sphere or oriented box against six planes.
// Pipeline: product, dot sum, absolute sum and compare stages, one register each, from
//   an accepted input transfer to out_valid.
// Throughput: one object per cycle; stages hold and bubbles collapse under out_stall.
// Reset: all plane registers clear to zero and the pipeline empties.
module frustum_sphere_box_cull #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fsbc_pkg::ADDR_W-1:0]       paddr,
    input  logic [fsbc_pkg::WORD_W-1:0]       pwdata,
    output logic [fsbc_pkg::WORD_W-1:0]       prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              opcode,
    input  logic [fsbc_pkg::WORD_W-1:0]       center,
    input  logic signed [fsbc_pkg::RAD_W-1:0] radius,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_r,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_s,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_t,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              visible
);

    localparam int DOT_W  = 2 * COMPONENT_BITS + 2;
    localparam int SABS_W = 2 * COMPONENT_BITS + 3;
    localparam int CMP_W  = (2 * COMPONENT_BITS + 5 > 25) ? 2 * COMPONENT_BITS + 5 : 25;

    fsbc_pkg::word_t [fsbc_pkg::PLANE_COUNT-1:0] planes;
    fsbc_pkg::word_t [fsbc_pkg::VEC_COUNT-1:0]   vecs;
    fsbc_pkg::stage_ctl_t                        ctl;

    logic signed [DOT_W-1:0] dc_w   [fsbc_pkg::PLANE_COUNT];
    logic [SABS_W-1:0]       sabs_w [fsbc_pkg::PLANE_COUNT];
    logic [fsbc_pkg::PLANE_COUNT-1:0] cull;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ready1, ready2, ready3, ready4;
    logic op1_reg, op2_reg, op3_reg;
    logic signed [fsbc_pkg::RAD_W-1:0] rad1_reg, rad2_reg, rad3_reg;
    logic visible_reg;
    logic visible_next;

    fsbc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // a stage loads when it is empty or its content moves on
    assign ready4 = !v4_reg || !out_stall;
    assign ready3 = !v3_reg || ready4;
    assign ready2 = !v2_reg || ready3;
    assign ready1 = !v1_reg || ready2;
    assign in_stall = !ready1;

    assign ctl.adv1 = ready1;
    assign ctl.adv2 = ready2;
    assign ctl.adv3 = ready3;

    assign vecs = {axis_t, axis_s, axis_r, center};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ready1)
            begin
                v1_reg <= in_valid;
            end
            if (ready2)
            begin
                v2_reg <= v1_reg;
            end
            if (ready3)
            begin
                v3_reg <= v2_reg;
            end
            if (ready4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready1)
        begin
            op1_reg  <= opcode;
            rad1_reg <= radius;
        end
        if (ready2)
        begin
            op2_reg  <= op1_reg;
            rad2_reg <= rad1_reg;
        end
        if (ready3)
        begin
            op3_reg  <= op2_reg;
            rad3_reg <= rad2_reg;
        end
        if (ready4)
        begin
            visible_reg <= visible_next;
        end
    end

    for (genvar p = 0; p < fsbc_pkg::PLANE_COUNT; p++)
    begin : g_plane
        logic [CMP_W-1:0] box_lhs;
        logic [CMP_W-1:0] sph_lhs;

        fsbc_plane #(
            .COMPONENT_BITS (COMPONENT_BITS)
        ) u_plane (
            .clk   (clk),
            .ctl   (ctl),
            .plane (planes[p]),
            .vecs  (vecs),
            .dc    (dc_w[p]),
            .sabs  (sabs_w[p])
        );

        // box: 2*dc + sum|d| < 0 ; sphere: dc + radius*256 < 0
        assign box_lhs = (CMP_W'(dc_w[p]) << 1) + CMP_W'(sabs_w[p]);
        assign sph_lhs = CMP_W'(dc_w[p]) + (CMP_W'(rad3_reg) << fsbc_pkg::RAD_SHIFT);
        assign cull[p] = (op3_reg == fsbc_pkg::OP_BOX) ? box_lhs[CMP_W-1]
                                                       : sph_lhs[CMP_W-1];
    end

    assign visible_next = ~|cull;
    assign visible      = visible_reg;
    assign out_valid    = v4_reg;

    a_free_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while output stage empty");

    a_transfer_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted transfer lost at stage 1");

    a_stage3_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && ready4) |=> out_valid)
        else $error("item in stage 3 did not reach output");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && v3_reg && out_valid && out_stall) |=> (v2_reg && v3_reg))
        else $error("stalled pipeline dropped an item");

endmodule

@@ sim/frustum_cull_check.sv @@
// Checker for the frustum cull block: watches the register bus and both channels, predicts, compares.
`timescale 1ns / 1ps
module frustum_cull_check #(
    parameter int COMPONENT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic                              pready,
    input  logic [fsbc_pkg::ADDR_W-1:0]       paddr,
    input  logic [fsbc_pkg::WORD_W-1:0]       pwdata,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              opcode,
    input  logic [fsbc_pkg::WORD_W-1:0]       center,
    input  logic signed [fsbc_pkg::RAD_W-1:0] radius,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_r,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_s,
    input  logic [fsbc_pkg::WORD_W-1:0]       axis_t,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              visible,
    output int                                fail_count,
    output int                                pending
);

    // registers sit 8 bytes apart
    localparam int REG_SHIFT = 3;

    fsbc_pkg::word_t    plane_q [fsbc_pkg::PLANE_COUNT];
    logic               visible_due [$];
    fsbc_pkg::reg_idx_t widx;
    logic               due;
    int                 errs = 0;

    // Low COMPONENT_BITS of a lane as two's complement.
    function automatic longint lane_val(fsbc_pkg::word_t w, int k);
        logic [fsbc_pkg::LANE_STRIDE-1:0] raw;
        longint v;
        raw = w[k*fsbc_pkg::LANE_STRIDE +: fsbc_pkg::LANE_STRIDE];
        v = longint'(raw & ((1 << COMPONENT_BITS) - 1));
        if (raw[COMPONENT_BITS-1])
            v -= longint'(1) << COMPONENT_BITS;
        return v;
    endfunction

    // Exact Q16.16 four-lane dot product.
    function automatic longint plane_dot(fsbc_pkg::word_t p, fsbc_pkg::word_t v);
        longint acc;
        acc = 0;
        for (int k = 0; k < fsbc_pkg::LANE_COUNT; k++)
            acc += lane_val(p, k) * lane_val(v, k);
        return acc;
    endfunction

    function automatic longint mag(longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic logic cull_visible(logic op, fsbc_pkg::word_t c,
                                          logic signed [fsbc_pkg::RAD_W-1:0] rad,
                                          fsbc_pkg::word_t ar, fsbc_pkg::word_t as_,
                                          fsbc_pkg::word_t at);
        logic   vis;
        longint dc;
        longint span;
        vis = 1'b1;
        for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
        begin
            dc = plane_dot(plane_q[i], c);
            if (op == fsbc_pkg::OP_SPHERE)
            begin
                if (dc < -(longint'(rad) * (longint'(1) << fsbc_pkg::RAD_SHIFT)))
                    vis = 1'b0;
            end
            else
            begin
                // box half-extent compared at double scale to stay exact
                span = mag(plane_dot(plane_q[i], ar)) + mag(plane_dot(plane_q[i], as_))
                     + mag(plane_dot(plane_q[i], at));
                if (2 * dc < -span)
                    vis = 1'b0;
            end
        end
        return vis;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (plane_q[i])
                plane_q[i] = '0;
            visible_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (visible_due.size() == 0)
                begin
                    $error("visible transfer with no expectation: got %0b", visible);
                    errs++;
                end
                else
                begin
                    due = visible_due.pop_front();
                    if (visible !== due)
                    begin
                        $error("visible mismatch: expected %0b, got %0b", due, visible);
                        errs++;
                    end
                end
            end
            if (in_valid && !in_stall)
                visible_due.push_back(cull_visible(opcode, center, radius,
                                                   axis_r, axis_s, axis_t));
            if (psel && penable && pwrite && pready)
            begin
                widx = fsbc_pkg::reg_idx_t'(paddr >> REG_SHIFT);
                if (int'(widx) < fsbc_pkg::PLANE_COUNT)
                    plane_q[widx] = pwdata;
            end
        end
        pending    <= visible_due.size();
        fail_count <= errs;
    end

endmodule

@@ sim/tb_frustum_sphere_box_cull.sv @@
// Testbench top: clock, reset, plane setup, object stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps
module tb_frustum_sphere_box_cull;

    localparam int COMPONENT_BITS = 16;
    localparam int REG_BYTES      = 8;
    localparam int Q_ONE          = 256;
    localparam int SCENE_SPAN     = 2048;
    localparam int AXIS_SPAN      = 384;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 8;

    typedef enum int {
        CFG_FRUSTUM,
        CFG_TILTED,
        CFG_RANDOM,
        CFG_ZERO,
        CFG_MOST_NEG,
        CFG_MOST_POS
    } plane_set_t;

    logic                               clk;
    logic                               rst_n;
    logic                               psel;
    logic                               penable;
    logic                               pwrite;
    logic [fsbc_pkg::ADDR_W-1:0]        paddr;
    logic [fsbc_pkg::WORD_W-1:0]        pwdata;
    logic [fsbc_pkg::WORD_W-1:0]        prdata;
    logic                               pready;
    logic                               in_valid;
    logic                               in_stall;
    logic                               opcode;
    logic [fsbc_pkg::WORD_W-1:0]        center;
    logic signed [fsbc_pkg::RAD_W-1:0]  radius;
    logic [fsbc_pkg::WORD_W-1:0]        axis_r;
    logic [fsbc_pkg::WORD_W-1:0]        axis_s;
    logic [fsbc_pkg::WORD_W-1:0]        axis_t;
    logic                               out_valid;
    logic                               out_stall;
    logic                               visible;

    int fail_count;
    int pending;
    int tx_pct       = 0;
    int rx_pct       = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;

    frustum_sphere_box_cull #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .center(center), .radius(radius),
        .axis_r(axis_r), .axis_s(axis_s), .axis_t(axis_t),
        .out_valid(out_valid), .out_stall(out_stall), .visible(visible)
    );

    frustum_cull_check #(
        .COMPONENT_BITS(COMPONENT_BITS)
    ) u_cull_check (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .center(center), .radius(radius),
        .axis_r(axis_r), .axis_s(axis_s), .axis_t(axis_t),
        .out_valid(out_valid), .out_stall(out_stall), .visible(visible),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: random stalls, plus a long hold-off whenever one is requested.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (holds_served != holds_asked)
            begin
                holds_served++;
                hold_left = HOLD_CYCLES - 1;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < rx_pct);
        end
    end

    function automatic fsbc_pkg::word_t pack4(int x, int y, int z, int w);
        return {16'(w), 16'(z), 16'(y), 16'(x)};
    endfunction

    function automatic int rand_signed(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    function automatic fsbc_pkg::word_t rand_word();
        return {$urandom, $urandom};
    endfunction

    // Half-space on one axis, tilted at random when tilt > 0: left/right on x, bottom/top on y, near/far on z.
    function automatic fsbc_pkg::word_t frustum_plane(int idx, int half, int tilt);
        int coef [3];
        foreach (coef[k])
            coef[k] = (tilt > 0) ? rand_signed(tilt) : 0;
        coef[idx / 2] += (idx % 2 == 0) ? Q_ONE : -Q_ONE;
        return pack4(coef[0], coef[1], coef[2], half);
    endfunction

    task automatic write_reg(input int idx, input fsbc_pkg::word_t data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fsbc_pkg::ADDR_W'(idx * REG_BYTES);
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // fixed_half of 0 picks a random half-extent per plane
    task automatic load_planes(input plane_set_t kind, input int fixed_half);
        fsbc_pkg::word_t p;
        int              half;
        for (int i = 0; i < fsbc_pkg::PLANE_COUNT; i++)
        begin
            half = (fixed_half > 0) ? fixed_half : int'($urandom_range(1024, 256));
            case (kind)
                CFG_FRUSTUM:  p = frustum_plane(i, half, 0);
                CFG_TILTED:   p = frustum_plane(i, half, 32);
                CFG_RANDOM:   p = rand_word();
                CFG_ZERO:     p = '0;
                CFG_MOST_NEG: p = {fsbc_pkg::LANE_COUNT{16'h8000}};
                default:      p = {fsbc_pkg::LANE_COUNT{16'h7fff}};
            endcase
            write_reg(i, p);
        end
    endtask

    task automatic push_object(input logic op, input fsbc_pkg::word_t c,
                               input logic [15:0] rad, input fsbc_pkg::word_t box_r,
                               input fsbc_pkg::word_t box_s, input fsbc_pkg::word_t box_t);
        while ($urandom_range(99) < tx_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        center   <= c;
        radius   <= rad;
        axis_r   <= box_r;
        axis_s   <= box_s;
        axis_t   <= box_t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Mostly objects placed around the frustum, the rest raw bit patterns.
    task automatic push_random();
        logic            op;
        fsbc_pkg::word_t c;
        fsbc_pkg::word_t br;
        fsbc_pkg::word_t bs;
        fsbc_pkg::word_t bt;
        int              rad;
        op = 1'($urandom_range(1));
        if ($urandom_range(99) < 80)
        begin
            c   = pack4(rand_signed(SCENE_SPAN), rand_signed(SCENE_SPAN),
                        rand_signed(SCENE_SPAN), Q_ONE);
            rad = int'($urandom_range(896)) - 128;
            br  = pack4(rand_signed(AXIS_SPAN), rand_signed(AXIS_SPAN),
                        rand_signed(AXIS_SPAN), 0);
            bs  = pack4(rand_signed(AXIS_SPAN), rand_signed(AXIS_SPAN),
                        rand_signed(AXIS_SPAN), 0);
            bt  = pack4(rand_signed(AXIS_SPAN), rand_signed(AXIS_SPAN),
                        rand_signed(AXIS_SPAN), 0);
        end
        else
        begin
            c   = rand_word();
            rad = int'($urandom_range(16'hffff));
            br  = rand_word();
            bs  = rand_word();
            bt  = rand_word();
        end
        push_object(op, c, 16'(rad), br, bs, bt);
    endtask

    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending != 0);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_phase(input plane_set_t kind, input int count, input int tx,
                             input int rx, input logic hold);
        wait_idle();
        load_planes(kind, 0);
        tx_pct = tx;
        rx_pct = rx;
        if (hold)
            holds_asked++;
        repeat (count)
            push_random();
        in_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        in_valid <= 1'b0;
        opcode   <= fsbc_pkg::OP_SPHERE;
        center   <= '0;
        radius   <= '0;
        axis_r   <= '0;
        axis_s   <= '0;
        axis_t   <= '0;
        repeat (12)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: unit frustum with half-extent 4.0 on every axis.
        load_planes(CFG_FRUSTUM, 1024);
        push_object(fsbc_pkg::OP_SPHERE, pack4(0, 0, 0, Q_ONE), 0, '0, '0, '0);
        // on the left plane, then one LSB past it, then tie with radius
        push_object(fsbc_pkg::OP_SPHERE, pack4(-1024, 0, 0, Q_ONE), 0, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(-1025, 0, 0, Q_ONE), 0, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(-1025, 0, 0, Q_ONE), 1, '0, '0, '0);
        // negative radius makes the test stricter
        push_object(fsbc_pkg::OP_SPHERE, pack4(-1024, 0, 0, Q_ONE), 16'hffff, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(1025, 0, 0, Q_ONE), 0, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(0, 0, 3000, Q_ONE), 16'h7fff, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(0, 0, 0, Q_ONE), 16'h8000, '0, '0, '0);
        // box half-extent ties and absolute value of the edge dots
        push_object(fsbc_pkg::OP_BOX, pack4(-1025, 0, 0, Q_ONE), 0,
                    pack4(2, 0, 0, 0), '0, '0);
        push_object(fsbc_pkg::OP_BOX, pack4(-1025, 0, 0, Q_ONE), 0,
                    pack4(1, 0, 0, 0), '0, '0);
        push_object(fsbc_pkg::OP_BOX, pack4(-1025, 0, 0, Q_ONE), 0,
                    pack4(-2, 0, 0, 0), '0, '0);
        push_object(fsbc_pkg::OP_BOX, pack4(0, 0, -1100, Q_ONE), 0, '0, '0,
                    pack4(0, 0, 152, 0));
        push_object(fsbc_pkg::OP_BOX, pack4(0, 0, -1100, Q_ONE), 0, '0, '0,
                    pack4(0, 0, 151, 0));
        // unused fields carry junk
        push_object(fsbc_pkg::OP_BOX, pack4(0, 0, 0, Q_ONE), 16'h8000, '0, '0, '0);
        push_object(fsbc_pkg::OP_SPHERE, pack4(0, 0, 0, Q_ONE), 0, '1, '1, '1);
        // lane extremes
        push_object(fsbc_pkg::OP_SPHERE, {fsbc_pkg::LANE_COUNT{16'h8000}}, 16'h7fff,
                    '0, '0, '0);
        push_object(fsbc_pkg::OP_BOX, {fsbc_pkg::LANE_COUNT{16'h7fff}}, 0,
                    {fsbc_pkg::LANE_COUNT{16'h8000}}, {fsbc_pkg::LANE_COUNT{16'h8000}},
                    {fsbc_pkg::LANE_COUNT{16'h8000}});
        push_object(fsbc_pkg::OP_BOX, {fsbc_pkg::LANE_COUNT{16'h8000}}, 0,
                    {fsbc_pkg::LANE_COUNT{16'h7fff}}, {fsbc_pkg::LANE_COUNT{16'h7fff}},
                    {fsbc_pkg::LANE_COUNT{16'h7fff}});
        in_valid <= 1'b0;

        run_phase(CFG_FRUSTUM,  300, 0,  0,  1'b0);
        run_phase(CFG_TILTED,   250, 47, 0,  1'b0);
        run_phase(CFG_RANDOM,   200, 0,  47, 1'b0);
        run_phase(CFG_FRUSTUM,  300, 18, 18, 1'b0);
        // long receiver hold-off while objects keep coming
        run_phase(CFG_TILTED,   150, 0,  0,  1'b1);

        // writes past the last plane must be ignored
        wait_idle();
        write_reg(fsbc_pkg::PLANE_COUNT, rand_word());
        write_reg(fsbc_pkg::PLANE_COUNT + 1, rand_word());
        tx_pct = 0;
        rx_pct = 47;
        repeat (50)
            push_random();
        in_valid <= 1'b0;

        run_phase(CFG_ZERO,     100, 0,  47, 1'b0);
        run_phase(CFG_MOST_NEG, 150, 18, 18, 1'b0);
        run_phase(CFG_MOST_POS, 150, 0,  0,  1'b0);
        run_phase(CFG_TILTED,   250, 47, 0,  1'b0);

        rx_pct = 0;
        wait_idle();
        repeat (16)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
